@@ sv/bsim_pkg.sv @@
`default_nettype none

package bsim_pkg;

  // Largest map size; inputs at or above it produce a zero-filled map.
  localparam int MAX_RES = 64;

  // Field widths of the transactions.
  localparam int IN_W  = 8;
  localparam int IDX_W = 6;

  // Walk counters carry a sign bit so they can step one below zero.
  localparam int CNT_W  = IN_W + 1;
  localparam int ERR_W  = 10;
  localparam int STEP_W = 8;

  typedef logic [IN_W-1:0]         in_val_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [CNT_W-1:0] cnt_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [STEP_W-1:0]       step_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SHRINK,
    ST_STRETCH,
    ST_FINISH
  } run_state_t;

endpackage

`default_nettype wire

@@ sv/bsim_if.sv @@
`default_nettype none

// Request channel: one scale job per transaction.
interface bsim_req_if
  import bsim_pkg::*;
  ;
  logic    valid;
  logic    ready;
  in_val_t source_last;
  in_val_t dest_count;

  modport source (output valid, output source_last, output dest_count, input ready);
  modport sink (input valid, input source_last, input dest_count, output ready);
endinterface

// Response channel: one map entry per transaction.
interface bsim_rsp_if
  import bsim_pkg::*;
  ;
  logic valid;
  logic ready;
  idx_t dest_index;
  idx_t source_index;
  logic last_entry;

  modport source (output valid, output dest_index, output source_index,
                  output last_entry, input ready);
  modport sink (input valid, input dest_index, input source_index,
                input last_entry, output ready);
endinterface

`default_nettype wire

@@ sv/bresenham_scale_index_map_core.sv @@
// Channel  Dir  Payload                                  Handshake
// req      in   source_last[8], dest_count[8]            valid/ready
// rsp      out  dest_index[6], source_index[6], last[1]  valid/ready
//
// One request takes a setup step, one walk step per cycle while the response
// is not stalled (source_last+1 steps when shrinking, dest_count+1 when
// stretching, MAX_RES for a zero fill) and a finish step.
// A pending entry is held back one step so the final one can carry last_entry.
// Reset (rst, synchronous) returns the sequencer to idle and empties the output.
// A stalled response holds the walk only on steps that produce an entry.
`default_nettype none

module bresenham_scale_index_map_core
  import bsim_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  bsim_req_if.sink    req,
  bsim_rsp_if.source  rsp
);

  localparam int MaxLast = MAX_RES - 1;

  // Sequencer and walk registers.
  run_state_t state, state_next;
  err_t       err, err_next;
  cnt_t       sx, sx_next;
  cnt_t       sy, sy_next;
  step_t      step_up, step_up_next;
  step_t      step_down, step_down_next;

  // One-entry hold stage and output register.
  logic hold_valid, hold_valid_next;
  idx_t hold_dest, hold_dest_next;
  idx_t hold_src, hold_src_next;
  logic out_valid, out_valid_next;
  idx_t out_dest, out_dest_next;
  idx_t out_src, out_src_next;
  logic out_last, out_last_next;

  // Shared error unit and its decisions.
  logic err_le0;
  err_t addend;
  err_t err_sum;
  logic out_free;
  logic emit;
  idx_t emit_dest;
  idx_t emit_src;
  logic advance;
  cnt_t in_sx;
  cnt_t in_sy;

  assign in_sx = cnt_t'({1'b0, req.source_last});
  assign in_sy = cnt_t'({1'b0, req.dest_count});

  assign err_le0 = err[ERR_W-1] || (err == '0);
  assign addend  = err_le0 ? err_t'({2'b00, step_up}) : -err_t'({2'b00, step_down});
  assign err_sum = err + addend;
  assign out_free = !out_valid || rsp.ready;

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.dest_index   = out_dest;
  assign rsp.source_index = out_src;
  assign rsp.last_entry   = out_last;

  // Entry produced by the current walk step, if any.
  always_comb begin
    emit      = 1'b0;
    emit_dest = '0;
    emit_src  = '0;
    case (state)
      ST_FILL: begin
        emit      = 1'b1;
        emit_dest = sy[IDX_W-1:0];
      end
      ST_SHRINK: begin
        emit      = err_le0 && !sy[CNT_W-1] && (sy != '0);
        emit_dest = idx_t'(sy - cnt_t'(1));
        emit_src  = sx[IDX_W-1:0];
      end
      ST_STRETCH: begin
        emit      = 1'b1;
        emit_dest = sy[IDX_W-1:0];
        emit_src  = sx[CNT_W-1] ? '0 : sx[IDX_W-1:0];
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // A step that pushes the held entry out needs room in the output register.
  assign advance = !(emit && hold_valid && !out_free);

  // Next state and data path.
  always_comb begin
    state_next      = state;
    err_next        = err;
    sx_next         = sx;
    sy_next         = sy;
    step_up_next    = step_up;
    step_down_next  = step_down;
    hold_valid_next = hold_valid;
    hold_dest_next  = hold_dest;
    hold_src_next   = hold_src;
    out_valid_next  = out_valid && !rsp.ready;
    out_dest_next   = out_dest;
    out_src_next    = out_src;
    out_last_next   = out_last;

    // Emitted entry enters the hold stage; the previous one moves to output.
    if (emit && advance) begin
      if (hold_valid) begin
        out_valid_next = 1'b1;
        out_dest_next  = hold_dest;
        out_src_next   = hold_src;
        out_last_next  = 1'b0;
      end
      hold_valid_next = 1'b1;
      hold_dest_next  = emit_dest;
      hold_src_next   = emit_src;
    end

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.source_last >= in_val_t'(MAX_RES) ||
              req.dest_count >= in_val_t'(MAX_RES)) begin
            sx_next    = '0;
            sy_next    = '0;
            state_next = ST_FILL;
          end else if (req.source_last > req.dest_count) begin
            step_down_next = {req.dest_count[STEP_W-2:0], 1'b0};
            step_up_next   = {req.source_last[STEP_W-2:0], 1'b0}
                           - {req.dest_count[STEP_W-2:0], 1'b0};
            err_next       = err_t'({req.source_last[STEP_W-2:0], 1'b0})
                           - err_t'({req.dest_count[STEP_W-2:0], 1'b0});
            sx_next        = in_sx;
            sy_next        = in_sy;
            state_next     = ST_SHRINK;
          end else begin
            step_down_next = {req.source_last[STEP_W-2:0], 1'b0};
            step_up_next   = {req.dest_count[STEP_W-2:0], 1'b0}
                           - {req.source_last[STEP_W-2:0], 1'b0};
            err_next       = err_t'({req.dest_count[STEP_W-2:0], 1'b0})
                           - err_t'({req.source_last[STEP_W-2:0], 1'b0});
            sx_next        = in_sx;
            sy_next        = in_sy;
            state_next     = ST_STRETCH;
          end
        end
      end

      ST_FILL: begin
        if (advance) begin
          if (sy == cnt_t'(MaxLast)) begin
            sy_next    = '0;
            state_next = ST_FINISH;
          end else begin
            sy_next = sy + cnt_t'(1);
          end
        end
      end

      // Walk the source coordinates; the destination steps on underflow.
      ST_SHRINK: begin
        if (advance) begin
          err_next = err_sum;
          if (err_le0) begin
            sy_next = sy - cnt_t'(1);
          end
          if (sx == '0) begin
            state_next = ST_FINISH;
          end else begin
            sx_next = sx - cnt_t'(1);
          end
        end
      end

      // Walk the destination coordinates; the source steps on underflow.
      ST_STRETCH: begin
        if (advance) begin
          err_next = err_sum;
          if (err_le0) begin
            sx_next = sx - cnt_t'(1);
          end
          if (sy == '0) begin
            state_next = ST_FINISH;
          end else begin
            sy_next = sy - cnt_t'(1);
          end
        end
      end

      // Release the held entry as the final one of the run.
      ST_FINISH: begin
        if (!hold_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_dest_next   = hold_dest;
          out_src_next    = hold_src;
          out_last_next   = 1'b1;
          hold_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      err        <= '0;
      sx         <= '0;
      sy         <= '0;
    end else begin
      state      <= state_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
      err        <= err_next;
      sx         <= sx_next;
      sy         <= sy_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    step_up   <= step_up_next;
    step_down <= step_down_next;
    hold_dest <= hold_dest_next;
    hold_src  <= hold_src_next;
    out_dest  <= out_dest_next;
    out_src   <= out_src_next;
    out_last  <= out_last_next;
  end

endmodule

`default_nettype wire
